// ===== hdl/keyframe_track_sampler_assert.svh =====
// Assertion macros for the keyframe track sampler checker.
`ifndef KEYFRAME_TRACK_SAMPLER_ASSERT_SVH
`define KEYFRAME_TRACK_SAMPLER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define KTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/kts_pkg.sv =====
package kts_pkg;

   localparam int MAX_KEYS = 64;
   localparam int IDX_W    = $clog2(MAX_KEYS);
   localparam int SEG_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int FRAC_W   = 16;
   localparam int STEP_W   = $clog2(FRAC_W);

   localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(FRAC_W - 1);
   localparam logic [STEP_W-1:0] BLEND_LAST = STEP_W'(3);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   localparam logic [COUNT_W-1:0] KEY_COUNT_RESET = COUNT_W'(1);

   typedef struct packed {
      logic               opcode;
      logic [5:0]         key_slot;
      logic [31:0]        key_time;
      logic signed [31:0] key_x;
      logic signed [31:0] key_y;
      logic signed [31:0] key_z;
      logic [31:0]        query_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [SEG_W-1:0]   segment;
      logic               held;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        key_time;
      logic signed [31:0] key_x;
      logic signed [31:0] key_y;
      logic signed [31:0] key_z;
   } key_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD0,
      ST_SCAN,
      ST_DIVIDE,
      ST_BLEND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             wr_en;
      logic             latch_req;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             prev_load;
      logic             div_load;
      logic             div_step;
      logic             mul_en;
      logic [1:0]       mul_sel;
      logic             acc_en;
      logic             emit_held;
      logic             emit_blend;
      logic [SEG_W-1:0] seg;
   } cmd_type;

   typedef struct packed {
      logic q_lt_cur;
   } status_type;

   // key index to the 6-bit segment field (truncates or zero-extends)
   function automatic logic [SEG_W-1:0] to_seg(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SEG_W-1:0] wide;
      wide = {{SEG_W{1'b0}}, idx};
      return wide[SEG_W-1:0];
   endfunction

   // index of the last valid key: zero count acts as one, large counts saturate
   function automatic logic [IDX_W-1:0] last_index(input logic [COUNT_W-1:0] kc);
      logic [31:0] k32;
      logic [31:0] last;
      k32 = {{(32-COUNT_W){1'b0}}, kc};
      if (k32 == 32'd0) begin
         last = 32'd0;
      end else if (k32 > 32'(MAX_KEYS)) begin
         last = 32'(MAX_KEYS - 1);
      end else begin
         last = k32 - 32'd1;
      end
      return last[IDX_W-1:0];
   endfunction

endpackage

// ===== hdl/kts_datapath.sv =====
module kts_datapath
   import kts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_word,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output rsp_type    rsp_word
);

   key_type mem [MAX_KEYS];

   key_type            rd_ff;
   key_type            prev_ff;
   logic [31:0]        query_ff;
   logic [31:0]        rem_ff;
   logic [31:0]        den_ff;
   logic [FRAC_W-1:0]  quo_ff;
   logic [SEG_W-1:0]   seg_ff;
   logic signed [49:0] prod_ff;
   logic [1:0]         prod_sel_ff;
   logic signed [31:0] res_x_ff;
   logic signed [31:0] res_y_ff;
   logic signed [31:0] res_z_ff;
   rsp_type            rsp_ff;
   logic               strobe_ff;

   logic [IDX_W+SEG_W-1:0] slot_wide;
   logic [IDX_W-1:0]       wr_addr;
   logic                   slot_ok;
   logic                   q_early;
   logic [32:0]            rem_shift;
   logic                   rem_ge;
   logic [32:0]            rem_sub;
   logic signed [31:0]     mul_a;
   logic signed [31:0]     mul_b;
   logic signed [32:0]     diff;
   logic signed [16:0]     fct;
   logic signed [49:0]     prod_in;
   logic signed [49:0]     prod_sh;
   logic signed [31:0]     acc_base;
   logic signed [31:0]     acc_sum;

   assign slot_wide = {{IDX_W{1'b0}}, req_word.key_slot};
   assign wr_addr   = slot_wide[IDX_W-1:0];
   assign slot_ok   = (slot_wide < (IDX_W+SEG_W)'(MAX_KEYS));

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en && slot_ok) begin
         mem[wr_addr] <= '{req_word.key_time, req_word.key_x,
                           req_word.key_y, req_word.key_z};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   assign status.q_lt_cur = (query_ff < rd_ff.key_time);
   assign q_early         = (query_ff < prev_ff.key_time);

   // restoring divider, one quotient bit per step
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, den_ff});
   assign rem_sub   = rem_shift - {1'b0, den_ff};

   always_comb begin
      unique case (cmd.mul_sel)
         COMP_X: begin
            mul_a = prev_ff.key_x;
            mul_b = rd_ff.key_x;
         end
         COMP_Y: begin
            mul_a = prev_ff.key_y;
            mul_b = rd_ff.key_y;
         end
         COMP_Z: begin
            mul_a = prev_ff.key_z;
            mul_b = rd_ff.key_z;
         end
         default: begin
            mul_a = prev_ff.key_x;
            mul_b = rd_ff.key_x;
         end
      endcase
   end

   assign diff    = {mul_b[31], mul_b} - {mul_a[31], mul_a};
   assign fct     = {1'b0, quo_ff};
   assign prod_in = diff * fct;
   assign prod_sh = prod_ff >>> FRAC_W;

   always_comb begin
      unique case (prod_sel_ff)
         COMP_X:  acc_base = prev_ff.key_x;
         COMP_Y:  acc_base = prev_ff.key_y;
         COMP_Z:  acc_base = prev_ff.key_z;
         default: acc_base = prev_ff.key_x;
      endcase
   end

   // result lies between the two keys, so the low word is exact
   assign acc_sum = acc_base + prod_sh[31:0];

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         query_ff <= req_word.query_time;
      end
      if (cmd.prev_load) begin
         prev_ff <= rd_ff;
      end
      if (cmd.div_load) begin
         // early query: all-ones divisor keeps the factor at zero, even on
         // an empty segment
         rem_ff <= q_early ? 32'd0 : (query_ff - prev_ff.key_time);
         den_ff <= q_early ? 32'hFFFF_FFFF : (rd_ff.key_time - prev_ff.key_time);
         quo_ff <= '0;
         seg_ff <= cmd.seg;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_sub[31:0] : rem_shift[31:0];
         quo_ff <= {quo_ff[FRAC_W-2:0], rem_ge};
      end
      if (cmd.mul_en) begin
         prod_ff     <= prod_in;
         prod_sel_ff <= cmd.mul_sel;
      end
      if (cmd.acc_en) begin
         unique case (prod_sel_ff)
            COMP_X:  res_x_ff <= acc_sum;
            COMP_Y:  res_y_ff <= acc_sum;
            COMP_Z:  res_z_ff <= acc_sum;
            default: res_x_ff <= acc_sum;
         endcase
      end
      if (cmd.emit_held) begin
         rsp_ff <= '{rd_ff.key_x, rd_ff.key_y, rd_ff.key_z, cmd.seg, 1'b1};
      end else if (cmd.emit_blend) begin
         rsp_ff <= '{res_x_ff, res_y_ff, res_z_ff, seg_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_held | cmd.emit_blend;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== hdl/kts_ctrl.sv =====
module kts_ctrl
   import kts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_opcode,
   output logic               busy,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_wdata,
   input  status_type         status,
   output cmd_type            cmd
);

   state_type          state_ff;
   state_type          state_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic [COUNT_W-1:0] kc_ff;
   logic [COUNT_W-1:0] kc_in;

   logic             accept;
   logic [IDX_W-1:0] last;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign last      = last_index(kc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
         kc_ff    <= KEY_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         kc_ff    <= kc_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_SAMPLE)) begin
               state_in = ST_LOAD0;
            end
         end
         ST_LOAD0: begin
            state_in = (last == '0) ? ST_IDLE : ST_SCAN;
         end
         ST_SCAN: begin
            priority if (status.q_lt_cur) begin
               state_in = ST_DIVIDE;
            end else if (idx_ff == last) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (step_ff == DIV_LAST) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (step_ff == BLEND_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and counters
   always_comb begin
      cmd     = '0;
      idx_in  = idx_ff;
      step_in = step_ff;
      kc_in   = kc_ff;
      if (csr_valid && csr_ready) begin
         kc_in = csr_wdata;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.wr_en     = (req_opcode == OP_WRITE);
               cmd.latch_req = (req_opcode == OP_SAMPLE);
               cmd.rd_en     = (req_opcode == OP_SAMPLE);
               cmd.rd_addr   = '0;
               idx_in        = '0;
            end
         end
         ST_LOAD0: begin
            if (last == '0) begin
               cmd.emit_held = 1'b1;
               cmd.seg       = '0;
            end else begin
               cmd.prev_load = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_addr   = IDX_W'(1);
               idx_in        = IDX_W'(1);
            end
         end
         ST_SCAN: begin
            priority if (status.q_lt_cur) begin
               cmd.div_load = 1'b1;
               cmd.seg      = to_seg(idx_ff - 1'b1);
               step_in      = '0;
            end else if (idx_ff == last) begin
               cmd.emit_held = 1'b1;
               cmd.seg       = to_seg(idx_ff);
            end else begin
               cmd.prev_load = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_addr   = idx_ff + 1'b1;
               idx_in        = idx_ff + 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = (step_ff == DIV_LAST) ? '0 : step_ff + 1'b1;
         end
         ST_BLEND: begin
            cmd.mul_en  = (step_ff != BLEND_LAST);
            cmd.mul_sel = step_ff[1:0];
            cmd.acc_en  = (step_ff != '0);
            step_in     = step_ff + 1'b1;
         end
         ST_FINISH: begin
            cmd.emit_blend = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hdl/keyframe_track_sampler.sv =====
// Keyframe track sampler: a table of up to MAX_KEYS keys (time plus xyz,
// Q16.16), written one key per word and sampled by linear interpolation.
// A write word is taken while idle and busy stays low. A sample word
// raises busy; with a single key busy is high for one cycle. Otherwise the
// single-port key table is scanned one key per cycle, and a query landing
// in the segment that starts at key k is answered once the scan reaches
// key k + 1, the divider has made one step per quotient bit, the blend has
// run for x, y and z and a finish state has registered the result; a query
// at or past the last key holds the last value once the scan reaches it.
// Busy time is set by the scan and the radix-2 divider. rsp_strobe rises
// as busy drops and is high for exactly one cycle, and there is no
// back-pressure: the receiver must take the word in that cycle.
// key_count goes in through the csr channel, ready whenever not busy.
module keyframe_track_sampler
   import kts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  req_type            req_word,
   // result channel, one-cycle strobe, cannot be stalled
   output logic               rsp_strobe,
   output rsp_type            rsp_word,
   // key_count register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer: scan index, divider / blend steps, key count
   kts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_word.opcode),
      .busy       (busy),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .cmd        (cmd)
   );

   // key table, divider, shared multiplier and result register
   kts_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== hdl/kts_checker.sv =====
`include "keyframe_track_sampler_assert.svh"

module kts_checker
   import kts_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input req_type            req_word,
   input logic               rsp_strobe,
   input logic               csr_valid,
   input logic               csr_ready
);

   `KTS_ASSERT_NEXT(a_sample_busy, clock, reset, start && !busy && (req_word.opcode == OP_SAMPLE), busy, "sample did not raise busy")
   `KTS_ASSERT_NEXT(a_accept_no_strobe, clock, reset, start && !busy, !rsp_strobe, "result strobe right after an accept")
   `KTS_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result strobe while busy")
   `KTS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result strobe longer than one cycle")
   `KTS_ASSERT_NOW(a_csr_idle, clock, reset, csr_valid && csr_ready, !busy, "key_count written while busy")

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (.*);

// ===== test/track_sample_checker.sv =====
module track_sample_checker
   import kts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_word,
   input  logic               rsp_strobe,
   input  rsp_type            rsp_word,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_wdata,
   output int                 mismatches,
   output int                 pending,
   output int                 samples_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   key_type            key_store [MAX_KEYS];
   logic [COUNT_W-1:0] track_len;
   rsp_type            expected_samples [$];
   rsp_type            want;

   initial begin
      mismatches      = 0;
      pending         = 0;
      samples_checked = 0;
   end

   // a + floor((b - a) * f / 2^16)
   function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic [15:0]        f);
      longint prod;
      prod = (longint'(b) - longint'(a)) * longint'({48'd0, f});
      return 32'(longint'(a) + (prod >>> 16));
   endfunction

   function automatic rsp_type interpolate_track(input logic [31:0] q);
      int          n;
      int          i;
      logic [31:0] t0;
      logic [31:0] t1;
      logic [47:0] num;
      logic [15:0] f;
      rsp_type     r;
      if (track_len == '0) begin
         n = 1;
      end else if (int'(track_len) > MAX_KEYS) begin
         n = MAX_KEYS;
      end else begin
         n = int'(track_len);
      end
      // held on the last key unless a segment catches the query
      r.out_x   = key_store[n-1].key_x;
      r.out_y   = key_store[n-1].key_y;
      r.out_z   = key_store[n-1].key_z;
      r.segment = SEG_W'(n - 1);
      r.held    = 1'b1;
      for (i = 0; i + 1 < n; i++) begin
         t0 = key_store[i].key_time;
         t1 = key_store[i+1].key_time;
         if (q < t1) begin
            f = '0;
            if (q >= t0) begin
               num = {q - t0, 16'd0};
               f   = 16'(num / {16'd0, t1 - t0});
            end
            r.out_x   = lerp(key_store[i].key_x, key_store[i+1].key_x, f);
            r.out_y   = lerp(key_store[i].key_y, key_store[i+1].key_y, f);
            r.out_z   = lerp(key_store[i].key_z, key_store[i+1].key_z, f);
            r.segment = SEG_W'(i);
            r.held    = 1'b0;
            return r;
         end
      end
      return r;
   endfunction

   task automatic compare_field(input string label, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         $display("%0t ns: %s expected %h, got %h", $time, label, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         track_len = KEY_COUNT_RESET;
         expected_samples.delete();
         foreach (key_store[k]) begin
            key_store[k] = '0;
         end
      end else begin
         if (rsp_strobe) begin
            if (expected_samples.size() == 0) begin
               mismatches++;
               $display("%0t ns: result word with no sample outstanding, got %h",
                        $time, rsp_word);
            end else begin
               want = expected_samples.pop_front();
               compare_field("out_x", want.out_x, rsp_word.out_x);
               compare_field("out_y", want.out_y, rsp_word.out_y);
               compare_field("out_z", want.out_z, rsp_word.out_z);
               compare_field("segment", 32'(want.segment), 32'(rsp_word.segment));
               compare_field("held", 32'(want.held), 32'(rsp_word.held));
               samples_checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            track_len = csr_wdata;
         end
         if (start && !busy) begin
            if (req_word.opcode == OP_WRITE) begin
               key_store[req_word.key_slot] = '{key_time: req_word.key_time,
                                                key_x: req_word.key_x,
                                                key_y: req_word.key_y,
                                                key_z: req_word.key_z};
            end else begin
               expected_samples.insert(expected_samples.size(),
                                       interpolate_track(req_word.query_time));
            end
         end
      end
      pending = expected_samples.size();
   end

endmodule

// ===== test/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kts_pkg::*;

   // stimulus stops once this many words have gone in; idling ends near the close
   localparam int STIM_ITEMS = 1050;
   localparam int QUIET_FROM = 980;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   req_type            req_word  = '0;
   logic               rsp_strobe;
   rsp_type            rsp_word;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_wdata = '0;

   int mismatches;
   int pending;
   int samples_checked;

   int items_sent  = 0;
   int writes_sent = 0;
   int samples_sent = 0;
   int settings    = 0;
   int gap_pct     = 0;

   // key times as last written, used to aim queries at the track
   logic [31:0] track_time [MAX_KEYS];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   keyframe_track_sampler uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   track_sample_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_word        (req_word),
      .rsp_strobe      (rsp_strobe),
      .rsp_word        (rsp_word),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .pending         (pending),
      .samples_checked (samples_checked)
   );

   // Drive one word. Inputs move on the falling edge; the word is taken at
   // the first rising edge with busy low. An optional idle burst goes first,
   // with start low, so gaps land at any point of the block's work.
   task automatic send_word(input req_type w);
      int gap;
      gap = 0;
      if (items_sent < QUIET_FROM && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 12);
      end
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // mostly full-range noise, now and then a boundary value
   function automatic logic [31:0] key_value();
      case ($urandom_range(0, 11))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic write_key(input logic [5:0] slot, input logic [31:0] t,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
      req_type w;
      w.opcode     = OP_WRITE;
      w.key_slot   = slot;
      w.key_time   = t;
      w.key_x      = x;
      w.key_y      = y;
      w.key_z      = z;
      w.query_time = $urandom;   // ignored on a write
      track_time[slot] = t;
      send_word(w);
      writes_sent++;
   endtask

   task automatic sample_at(input logic [31:0] q);
      req_type w;
      // key fields are don't-care on a sample; fill them with noise
      w.opcode     = OP_SAMPLE;
      w.key_slot   = 6'($urandom);
      w.key_time   = $urandom;
      w.key_x      = $urandom;
      w.key_y      = $urandom;
      w.key_z      = $urandom;
      w.query_time = q;
      send_word(w);
      samples_sent++;
   endtask

   // Register write only with the block idle: every result in, then a short
   // pause to cover a key write that may still be landing.
   task automatic set_key_count(input logic [COUNT_W-1:0] count);
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings++;
   endtask

   // Pick a query: on a key, just short of one, inside a segment, before the
   // first key, past the last, or anywhere.
   function automatic logic [31:0] pick_query(input int n);
      int          k;
      logic [31:0] lo;
      logic [31:0] hi;
      k  = $urandom_range(0, n - 1);
      lo = track_time[k];
      hi = (k + 1 < n) ? track_time[k+1] : lo;
      case ($urandom_range(0, 9))
         0: return lo;
         1: return lo - 32'd1;
         2: return $urandom;
         3: return (track_time[0] == 0) ? 32'd0 : $urandom_range(0, track_time[0] - 1);
         4: return track_time[n-1] + 32'($urandom_range(0, 255));
         default: begin
            if (hi > lo) begin
               return lo + $urandom_range(0, hi - lo - 1);
            end
            return $urandom;
         end
      endcase
   endfunction

   // One track setting: write the count, lay down a whole track, then sample
   // it with the odd stray key write mixed in.
   task automatic run_track(input logic [COUNT_W-1:0] count);
      int              n;
      int              k;
      int              shape;
      int              nsamp;
      longint unsigned room;
      longint unsigned stepmax;
      logic [31:0]     t;
      n = (count == 0) ? 1 : ((int'(count) > MAX_KEYS) ? MAX_KEYS : int'(count));
      set_key_count(count);
      case ($urandom_range(0, 2))
         0:       gap_pct = 0;
         1:       gap_pct = 15;
         default: gap_pct = 40;
      endcase

      // shape 0: scrambled times, 1: repeated times, else strictly ascending
      shape   = $urandom_range(0, 9);
      t       = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      room    = 64'hFFFF_FFFF - longint'(t);
      stepmax = room / longint'(n);
      if ($urandom_range(0, 1) == 0 && stepmax > 64'h4_0000) begin
         stepmax = 64'h4_0000;   // dense track, at most 2^18 ticks per key
      end
      if (stepmax == 0) begin
         stepmax = 1;
      end
      for (k = 0; k < n; k++) begin
         if (k > 0) begin
            case (shape)
               0: t = $urandom;
               1: t = t + (($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(1, 255)));
               default: t = t + $urandom_range(1, 32'(stepmax));
            endcase
         end else if (shape == 0) begin
            t = $urandom;
         end
         write_key(6'(k), t, key_value(), key_value(), key_value());
      end

      nsamp = $urandom_range(6, 20);
      for (k = 0; k < nsamp; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            write_key(6'($urandom), $urandom, key_value(), key_value(), key_value());
         end
         sample_at(pick_query(n));
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] count;
      int                 r;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // count is one after reset: key 0 comes back whatever the query
      write_key(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      sample_at(32'h0000_0000);
      sample_at(32'hFFFF_FFFF);

      // four keys: widest swings, an empty segment and a key at the top of time
      set_key_count(7'd4);
      write_key(6'd1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      write_key(6'd2, 32'h0002_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      write_key(6'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
      sample_at(32'h0000_0000);   // before the first key, factor clamps
      sample_at(32'h0001_0000);   // exactly on the first key
      sample_at(32'h0001_8000);   // halfway, opposite extremes
      sample_at(32'h0001_FFFF);   // factor just under one
      sample_at(32'h0002_0000);   // skips the empty segment
      sample_at(32'hFFFF_FFFE);   // last tick before the final key
      sample_at(32'hFFFF_FFFF);   // on the final key, held

      // count of zero acts as one key
      set_key_count(7'd0);
      sample_at($urandom);

      // --- random: count extremes first, then mostly short tracks ---
      run_track(7'd127);
      run_track(7'd64);
      run_track(7'd65);
      run_track(7'd2);
      run_track(7'd1);
      while (items_sent < STIM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            count = 7'($urandom_range(2, 8));
         end else if (r < 85) begin
            count = 7'($urandom_range(9, 63));
         end else if (r < 95) begin
            count = 7'($urandom_range(64, 127));
         end else begin
            count = 7'($urandom_range(0, 1));
         end
         run_track(count);
      end

      // drain: every sample answered, then room for a late stray strobe
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (120) @(negedge clock);

      $display("covered %0d key writes and %0d samples (%0d results checked)",
               writes_sent, samples_sent, samples_checked);
      $display("over %0d key_count settings from 0 to 127, with and without idle bursts",
               settings);
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #12_000_000;
      $display("timeout with %0d samples outstanding", pending);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
